/* rtl/core/fspa_pkg.sv */
// Package for the fixed-slot pool allocator.
// Holds the sizes, codes and transaction types shared by all rtl/core modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fspa_pkg;

	localparam int SLOTS       = 64;
	localparam int IDX_W       = $clog2(SLOTS);
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int SLOT_W      = 6;
	localparam int UNITS_W     = 8;
	localparam int UNIT_SHIFT  = 8;
	localparam int PROD_W      = SLOT_W + UNITS_W;
	localparam int OFFSET_W    = 22;
	localparam int BASE_W      = 48;
	localparam int ADDR_W      = 49;
	localparam int CFG_IDX_W   = 1;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FREED   = 2'd2,
		ST_DOUBLE  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLOT_SIZE = 1'b0,
		CFG_BASE      = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		action_t             action;
		logic [SLOT_W-1:0]   slot_id;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   granted_slot;
		logic [OFFSET_W-1:0] byte_offset;
		logic [ADDR_W-1:0]   device_address;
	} rsp_t;

	typedef struct packed {
		logic              push;
		logic              pop;
		logic [IDX_W-1:0]  push_id;
	} fq_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [IDX_W-1:0]  head_id;
	} fq_stat_t;

endpackage

`default_nettype wire

/* rtl/core/fspa_free_queue.sv */
// FIFO free list of slot ids with a prefetched head entry.
// Depends on fspa_pkg for sizes and the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module fspa_free_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fspa_pkg::fq_ctrl_t ctrl,
	output fspa_pkg::fq_stat_t   stat
);

	logic [fspa_pkg::IDX_W-1:0] mem_q [fspa_pkg::SLOTS];
	logic [fspa_pkg::SLOTS-1:0] written_q;
	logic [fspa_pkg::IDX_W-1:0] head_q;
	logic [fspa_pkg::IDX_W-1:0] tail_q;
	logic [fspa_pkg::CNT_W-1:0] count_q;
	logic [fspa_pkg::IDX_W-1:0] head_next;
	logic [fspa_pkg::IDX_W-1:0] tail_next;
	logic [fspa_pkg::IDX_W-1:0] mem_rd_q;
	logic                       written_rd_q;
	logic                       byp_q;
	logic [fspa_pkg::IDX_W-1:0] byp_id_q;

	always_comb begin
		head_next = head_q;
		if (ctrl.pop) begin
			head_next = (head_q == fspa_pkg::IDX_W'(fspa_pkg::SLOTS - 1)) ? '0 : head_q + 1'b1;
		end
		tail_next = (tail_q == fspa_pkg::IDX_W'(fspa_pkg::SLOTS - 1)) ? '0 : tail_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[tail_q] <= ctrl.push_id;
		end
		mem_rd_q <= mem_q[head_next];
		byp_id_q <= ctrl.push_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= fspa_pkg::CNT_W'(fspa_pkg::SLOTS);
			written_rd_q <= 1'b0;
			byp_q        <= 1'b0;
		end else begin
			head_q       <= head_next;
			written_rd_q <= written_q[head_next];
			byp_q        <= ctrl.push && (tail_q == head_next);
			if (ctrl.push) begin
				written_q[tail_q] <= 1'b1;
				tail_q            <= tail_next;
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop && !ctrl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// An entry never written reads as its own index, since the memory is not reset.
	always_comb begin
		stat.count = count_q;
		if (byp_q) begin
			stat.head_id = byp_id_q;
		end else if (written_rd_q) begin
			stat.head_id = mem_rd_q;
		end else begin
			stat.head_id = head_q;
		end
	end

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> count_q != '0)
		else $error("free queue popped while empty");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> count_q != fspa_pkg::CNT_W'(fspa_pkg::SLOTS))
		else $error("free queue pushed while full");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.push && ctrl.pop))
		else $error("free queue pushed and popped in one cycle");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == fspa_pkg::CNT_W'(fspa_pkg::SLOTS)) |-> head_q == tail_q)
		else $error("free queue pointers disagree with the count");

endmodule

`default_nettype wire

/* rtl/core/fspa_addr_calc.sv */
// Byte offset and device address of a granted slot.
// Depends on fspa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module fspa_addr_calc (
	input  wire logic [fspa_pkg::SLOT_W-1:0]   slot_id,
	input  wire logic [fspa_pkg::UNITS_W-1:0]  slot_size_units,
	input  wire logic [fspa_pkg::BASE_W-1:0]   base_address,
	output logic      [fspa_pkg::OFFSET_W-1:0] byte_offset,
	output logic      [fspa_pkg::ADDR_W-1:0]   device_address
);

	logic [fspa_pkg::PROD_W-1:0] prod;

	always_comb begin
		prod           = fspa_pkg::PROD_W'(slot_id) * fspa_pkg::PROD_W'(slot_size_units);
		byte_offset    = {prod, fspa_pkg::UNIT_SHIFT'(0)};
		device_address = fspa_pkg::ADDR_W'(base_address) + fspa_pkg::ADDR_W'(byte_offset);
	end

endmodule

`default_nettype wire

/* rtl/core/fixed_slot_pool_allocator_top.sv */
// Top level of the fixed-slot pool allocator.
// Instantiates fspa_free_queue and fspa_addr_calc; uses fspa_pkg types.
//
// Usage:
// Requests arrive on req with req_valid and req_stall; a transaction is taken
// at a rising edge with req_valid high and req_stall low. An allocate pops the
// oldest free slot id; a free returns a slot that is in use to the back of the
// list, and a free of a slot not in use is answered as a double free.
// Every request gives exactly one response on rsp, with rsp_valid and
// rsp_stall following the same rule.
// The request is registered, then the decision, the free list update and the
// address sum land in the response register. Throughput is one request per
// cycle while rsp_stall holds no response; the free list head is prefetched from
// its memory each cycle, so back-to-back allocates and frees need no bubbles.
// When rsp_stall holds a response, one more request can wait in the input
// register; after that req_stall rises until the response is taken.
// Reset empties both registers, fills the free list with ids 0 to 63 in order,
// clears the in-use map and sets slot size 1 and base address 0.
// Configuration writes on cfg are always ready and should be made while idle.
`timescale 1ns / 1ps
`default_nettype none

module fixed_slot_pool_allocator_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire fspa_pkg::req_t                  req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output fspa_pkg::rsp_t                       rsp,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fspa_pkg::BASE_W-1:0]     cfg_data
);

	fspa_pkg::req_t                    req_s1;
	logic                              vld_s1;
	fspa_pkg::rsp_t                    rsp_q;
	logic                              rsp_vld_q;
	logic [fspa_pkg::UNITS_W-1:0]      slot_size_q;
	logic [fspa_pkg::BASE_W-1:0]       base_q;
	logic [fspa_pkg::SLOTS-1:0]        in_use_q;
	fspa_pkg::fq_ctrl_t                fq_ctrl;
	fspa_pkg::fq_stat_t                fq_stat;
	fspa_pkg::rsp_t                    rsp_d;
	logic [fspa_pkg::OFFSET_W-1:0]     calc_offset;
	logic [fspa_pkg::ADDR_W-1:0]       calc_addr;
	logic                              adv;
	logic                              accept;
	logic                              grant;
	logic                              release_ok;

	assign cfg_ready = 1'b1;
	assign adv       = vld_s1 && (!rsp_vld_q || !rsp_stall);
	assign req_stall = vld_s1 && !adv;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	fspa_free_queue u_free_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fq_ctrl),
		.stat   (fq_stat)
	);

	fspa_addr_calc u_addr_calc (
		.slot_id         (fq_stat.head_id),
		.slot_size_units (slot_size_q),
		.base_address    (base_q),
		.byte_offset     (calc_offset),
		.device_address  (calc_addr)
	);

	always_comb begin
		grant      = (req_s1.action == fspa_pkg::ACT_ALLOC) && (fq_stat.count != '0);
		release_ok = (req_s1.action == fspa_pkg::ACT_FREE) && in_use_q[req_s1.slot_id]
			&& (fq_stat.count != fspa_pkg::CNT_W'(fspa_pkg::SLOTS));
		fq_ctrl.pop     = adv && grant;
		fq_ctrl.push    = adv && release_ok;
		fq_ctrl.push_id = req_s1.slot_id;
		rsp_d = '0;
		if (req_s1.action == fspa_pkg::ACT_ALLOC) begin
			if (grant) begin
				rsp_d.status         = fspa_pkg::ST_GRANTED;
				rsp_d.granted_slot   = fq_stat.head_id;
				rsp_d.byte_offset    = calc_offset;
				rsp_d.device_address = calc_addr;
			end else begin
				rsp_d.status = fspa_pkg::ST_EMPTY;
			end
		end else begin
			rsp_d.status = release_ok ? fspa_pkg::ST_FREED : fspa_pkg::ST_DOUBLE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			rsp_vld_q   <= 1'b0;
			slot_size_q <= fspa_pkg::UNITS_W'(1);
			base_q      <= '0;
			in_use_q    <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
			if (fq_ctrl.pop) begin
				in_use_q[fq_stat.head_id] <= 1'b1;
			end
			if (fq_ctrl.push) begin
				in_use_q[req_s1.slot_id] <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (fspa_pkg::cfg_reg_t'(cfg_index))
					fspa_pkg::CFG_SLOT_SIZE: begin
						slot_size_q <= cfg_data[fspa_pkg::UNITS_W-1:0];
					end
					fspa_pkg::CFG_BASE: begin
						base_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		fq_ctrl.pop |=> in_use_q[$past(fq_stat.head_id)])
		else $error("granted slot not marked in use");

	a_free_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fq_ctrl.push |=> !in_use_q[$past(req_s1.slot_id)])
		else $error("freed slot still marked in use");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> vld_s1 && rsp_vld_q)
		else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench for the fixed-slot pool allocator top level.
// Mirrors the free list, in-use map and address math to check every response in order.
// Depends on fspa_pkg and fixed_slot_pool_allocator_top.
`timescale 1ns / 1ps

module tb;
	import fspa_pkg::*;

	typedef logic [SLOT_W-1:0] slot_list_t [$];

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BASE_W-1:0]    cfg_data  = '0;

	logic [SLOT_W-1:0]  ring_ids [SLOTS];
	bit                 slot_busy [SLOTS];
	int                 ring_head;
	int                 ring_tail;
	int                 free_left;
	logic [UNITS_W-1:0] unit_size;
	logic [BASE_W-1:0]  pool_base;
	rsp_t               pool_answers [$];
	int                 error_count = 0;
	bit                 req_gapless = 1'b0;

	fixed_slot_pool_allocator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	function rsp_t pool_decide(input req_t r);
		rsp_t              a;
		logic [31:0]       off;
		logic [SLOT_W-1:0] id;
		a = '0;
		if (r.action == ACT_ALLOC) begin
			if (free_left == 0) begin
				a.status = ST_EMPTY;
			end else begin
				id = ring_ids[ring_head];
				ring_head = (ring_head + 1) % SLOTS;
				free_left--;
				slot_busy[id] = 1'b1;
				off = (32'(id) * 32'(unit_size)) << UNIT_SHIFT;
				a.status = ST_GRANTED;
				a.granted_slot = id;
				a.byte_offset = off[OFFSET_W-1:0];
				a.device_address = ADDR_W'(pool_base) + ADDR_W'(off);
			end
		end else if (!slot_busy[r.slot_id] || free_left >= SLOTS) begin
			a.status = ST_DOUBLE;
		end else begin
			slot_busy[r.slot_id] = 1'b0;
			ring_ids[ring_tail] = r.slot_id;
			ring_tail = (ring_tail + 1) % SLOTS;
			free_left++;
			a.status = ST_FREED;
		end
		return a;
	endfunction

	function slot_list_t busy_slots();
		slot_list_t ids;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_busy[i]) begin
				ids.push_back(SLOT_W'(i));
			end
		end
		return ids;
	endfunction

	function int idle_gap();
		int p;
		if (req_gapless) begin
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 55) begin
			return 0;
		end else if (p < 85) begin
			return $urandom_range(1, 3);
		end else if (p < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task report_mismatch(input string what);
		error_count++;
		if (error_count <= 100) begin
			$display("%0t: %s", $time, what);
		end
	endtask

	task send_req(input action_t act, input logic [SLOT_W-1:0] id);
		req_t r;
		int   gap;
		r.action = act;
		r.slot_id = id;
		gap = idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		pool_answers.push_back(pool_decide(r));
	endtask

	task wait_pool_quiet();
		req_valid <= 1'b0;
		while (pool_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_pool_reg(input cfg_reg_t idx, input logic [BASE_W-1:0] data);
		wait_pool_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SLOT_SIZE: unit_size = data[UNITS_W-1:0];
			CFG_BASE:      pool_base = data;
			default:       ;
		endcase
		repeat (2) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_answers
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pool_answers.size() == 0) begin
				report_mismatch($sformatf("response %h arrived with nothing pending", rsp));
			end else begin
				want = pool_answers.pop_front();
				if (rsp.status !== want.status) begin
					report_mismatch($sformatf("status got %s want %s",
						rsp.status.name(), want.status.name()));
				end
				if (rsp.granted_slot !== want.granted_slot) begin
					report_mismatch($sformatf("granted_slot got %0d want %0d",
						rsp.granted_slot, want.granted_slot));
				end
				if (rsp.byte_offset !== want.byte_offset) begin
					report_mismatch($sformatf("byte_offset got %h want %h",
						rsp.byte_offset, want.byte_offset));
				end
				if (rsp.device_address !== want.device_address) begin
					report_mismatch($sformatf("device_address got %h want %h",
						rsp.device_address, want.device_address));
				end
			end
		end
	end

	initial begin : rsp_backpressure
		int run;
		int hold;
		int p;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 9) == 0) begin
				run = $urandom_range(50, 200);
			end else begin
				run = $urandom_range(1, 8);
			end
			repeat (run) @(posedge clk);
			p = $urandom_range(0, 99);
			if (p < 80) begin
				hold = $urandom_range(1, 3);
			end else if (p < 96) begin
				hold = $urandom_range(4, 10);
			end else begin
				hold = $urandom_range(15, 40);
			end
			rsp_stall <= 1'b1;
			repeat (hold) @(posedge clk);
			rsp_stall <= 1'b0;
		end
	end

	task test_reset_state();
		send_req(ACT_ALLOC, SLOT_W'($urandom));
		send_req(ACT_ALLOC, '1);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_FREE, 6'd5);
		send_req(ACT_FREE, 6'd1);
		send_req(ACT_FREE, 6'd1);
		send_req(ACT_FREE, 6'd63);
		send_req(ACT_ALLOC, SLOT_W'($urandom));
	endtask

	task test_slot_size_extremes();
		write_pool_reg(CFG_SLOT_SIZE, '0);
		write_pool_reg(CFG_BASE, '1);
		send_req(ACT_ALLOC, SLOT_W'($urandom));
		send_req(ACT_ALLOC, SLOT_W'($urandom));
		write_pool_reg(CFG_SLOT_SIZE, 48'd255);
		write_pool_reg(CFG_BASE, '0);
		send_req(ACT_ALLOC, SLOT_W'($urandom));
		send_req(ACT_FREE, 6'd0);
		send_req(ACT_FREE, 6'd0);
	endtask

	task test_pool_exhaustion();
		slot_list_t       ids;
		int               pick;
		logic [SLOT_W-1:0] id;
		write_pool_reg(CFG_SLOT_SIZE, 48'd255);
		write_pool_reg(CFG_BASE, '1);
		while (free_left > 0) begin
			send_req(ACT_ALLOC, SLOT_W'($urandom));
		end
		repeat (3) send_req(ACT_ALLOC, SLOT_W'($urandom));
		ids = busy_slots();
		while (ids.size() != 0) begin
			pick = $urandom_range(0, ids.size() - 1);
			id = ids[pick];
			ids.delete(pick);
			send_req(ACT_FREE, id);
			if ($urandom_range(0, 4) == 0) begin
				send_req(ACT_FREE, id);
			end
		end
		repeat (4) send_req(ACT_ALLOC, SLOT_W'($urandom));
	endtask

	task test_random_traffic();
		slot_list_t        ids;
		int                alloc_pct;
		int                p;
		logic [BASE_W-1:0] base;
		for (int phase = 0; phase < 8; phase++) begin
			p = $urandom_range(0, 4);
			write_pool_reg(CFG_SLOT_SIZE, (p == 0) ? 48'd0 : (p == 1) ? 48'd1 :
				(p == 2) ? 48'd255 : BASE_W'($urandom_range(0, 255)));
			p = $urandom_range(0, 3);
			base = {16'($urandom), 32'($urandom)};
			write_pool_reg(CFG_BASE, (p == 0) ? '0 : (p == 1) ? '1 : base);
			alloc_pct = (phase == 0) ? 85 : (phase == 1) ? 15 : $urandom_range(20, 80);
			req_gapless = ($urandom_range(0, 3) == 0);
			repeat (200) begin
				p = $urandom_range(0, 99);
				if (p < 10) begin
					send_req(action_t'($urandom_range(0, 1)), SLOT_W'($urandom));
				end else if ($urandom_range(0, 99) < alloc_pct) begin
					send_req(ACT_ALLOC, SLOT_W'($urandom));
				end else begin
					ids = busy_slots();
					if (ids.size() == 0) begin
						send_req(ACT_FREE, SLOT_W'($urandom));
					end else begin
						send_req(ACT_FREE, ids[$urandom_range(0, ids.size() - 1)]);
					end
				end
			end
			req_gapless = 1'b0;
		end
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			ring_ids[i] = SLOT_W'(i);
			slot_busy[i] = 1'b0;
		end
		ring_head = 0;
		ring_tail = 0;
		free_left = SLOTS;
		unit_size = 8'd1;
		pool_base = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_state();
		test_slot_size_extremes();
		test_pool_exhaustion();
		test_random_traffic();
		wait_pool_quiet();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/fspa_pkg.sv
rtl/core/fspa_free_queue.sv
rtl/core/fspa_addr_calc.sv
rtl/core/fixed_slot_pool_allocator_top.sv
verif/tb.sv
